// ===== hw/rtl/uart_baud_divisor_encoder_defines.svh =====
// Assertion macros shared by the checker of the baud divisor encoder.
// Depends on nothing; the clock and reset names are those of the top-level ports.
`ifndef UART_BAUD_DIVISOR_ENCODER_DEFINES_SVH
`define UART_BAUD_DIVISOR_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UBDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UBDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ubde_pkg.sv =====
// Shared types, constants and the fraction code lookup of the baud divisor encoder.
// No dependencies; used by every module of the block.
package ubde_pkg;

  // Field widths.
  localparam int unsigned ReqW  = 24;
  localparam int unsigned RefW  = 28;
  localparam int unsigned BaseW = 24;
  localparam int unsigned DivW  = 28;
  localparam int unsigned ValW  = 16;
  localparam int unsigned IntW  = 14;
  localparam int unsigned CodeW = 3;

  // The base clock is the reference clock over sixteen.
  localparam int unsigned PreShift = 4;

  // Division by three: floor(2^26 / 3), then one correction step.
  localparam int unsigned ThirdShift = 26;
  localparam int unsigned ProdW      = 2 * (BaseW + 1);
  localparam int unsigned RemW       = BaseW + 2;
  localparam logic [BaseW:0] Recip3  = 25'd22369621;
  localparam int unsigned DivThree   = 3;

  // Reset values of the configuration registers.
  localparam logic [RefW-1:0] RefClkReset = 28'd48000000;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StUnsup    = 2'd1,
    StZeroRate = 2'd2
  } status_e;

  typedef enum logic {
    CfgRefClk  = 1'b0,
    CfgChipSup = 1'b1
  } cfg_reg_e;

  // Sideband that travels with an item through both dividers.
  typedef struct packed {
    status_e            status;
    logic [ReqW-1:0]    req;
    logic [BaseW-1:0]   base;
    logic [BaseW-1:0]   two_thirds;
    logic [DivW-1:0]    ratio;
  } side_t;

  // One finished result.
  typedef struct packed {
    status_e            status;
    logic [ReqW-1:0]    achieved;
    logic [ValW-1:0]    value;
    logic               index;
  } res_t;

  // Maps the eighths of the ratio onto the chip's fraction code.
  function automatic logic [CodeW-1:0] frac_code(input logic [CodeW-1:0] sel);
    logic [CodeW-1:0] code;
    unique case (sel)
      3'd0:    code = 3'd0;
      3'd1:    code = 3'd3;
      3'd2:    code = 3'd2;
      3'd3:    code = 3'd4;
      3'd4:    code = 3'd1;
      3'd5:    code = 3'd5;
      3'd6:    code = 3'd6;
      default: code = 3'd7;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/ubde_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on ubde_pkg for the operand width and the sideband type.
module ubde_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [ubde_pkg::DivW-1:0]   num_i,
  input  logic [ubde_pkg::DivW-1:0]   den_i,
  input  ubde_pkg::side_t             side_i,
  output logic                        valid_o,
  output logic [ubde_pkg::DivW-1:0]   quot_o,
  output ubde_pkg::side_t             side_o
);
  import ubde_pkg::*;

  localparam int unsigned Steps = DivW;

  logic [Steps-1:0] vld_q;
  logic [DivW-1:0]  rem_d  [Steps];
  logic [DivW-1:0]  rem_q  [Steps];
  logic [DivW-1:0]  nq_d   [Steps];
  logic [DivW-1:0]  nq_q   [Steps];
  logic [DivW-1:0]  den_d  [Steps];
  logic [DivW-1:0]  den_q  [Steps];
  side_t            side_d [Steps];
  side_t            side_q [Steps];

  // One shift, compare and subtract per stage. The numerator shifts out at the
  // top of nq while quotient bits shift in at the bottom.
  always_comb begin
    logic [DivW-1:0] rem_in;
    logic [DivW-1:0] nq_in;
    logic [DivW-1:0] den_in;
    logic [DivW:0]   trial;
    logic            qbit;
    for (int k = 0; k < Steps; k++) begin
      if (k == 0) begin
        rem_in    = '0;
        nq_in     = num_i;
        den_in    = den_i;
        side_d[k] = side_i;
      end else begin
        rem_in    = rem_q[k-1];
        nq_in     = nq_q[k-1];
        den_in    = den_q[k-1];
        side_d[k] = side_q[k-1];
      end
      trial = {rem_in, nq_in[DivW-1]};
      qbit  = (trial >= {1'b0, den_in});
      if (qbit) begin
        rem_d[k] = DivW'(trial - {1'b0, den_in});
      end else begin
        rem_d[k] = trial[DivW-1:0];
      end
      nq_d[k]  = {nq_in[DivW-2:0], qbit};
      den_d[k] = den_in;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Steps-2:0], valid_i};
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Steps; k++) begin
      rem_q[k]  <= rem_d[k];
      nq_q[k]   <= nq_d[k];
      den_q[k]  <= den_d[k];
      side_q[k] <= side_d[k];
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign quot_o  = nq_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// ===== hw/rtl/ubde_out_fifo.sv =====
// Result queue in front of the output register; absorbs the pipeline while stalled.
// Depends on ubde_pkg for the result type.
module ubde_out_fifo #(
  parameter int unsigned FifoDepth = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  ubde_pkg::res_t  wr_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ubde_pkg::res_t  out_data_o
);
  import ubde_pkg::*;

  localparam int unsigned PtrW  = $clog2(FifoDepth);
  localparam int unsigned FillW = $clog2(FifoDepth + 1);

  res_t             mem [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_data_q;
  logic             pop;

  // Move the oldest entry into the output register whenever it is free.
  assign pop = (fill_q != '0) && (!out_valid_q || !out_stall_i);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_valid_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    fill_d = fill_q + FillW'(wr_valid_i) - FillW'(pop);
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_data_q <= mem[rd_ptr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/uart_baud_divisor_encoder.sv =====
// Top level of the UART baud divisor encoder: config registers, pipeline and credits.
// Depends on ubde_pkg, ubde_div and ubde_out_fifo.
//
//  Channel   Direction  Handshake                    Payload
//  in        sink       in_valid_i / in_stall_o      requested_baud_i
//  out       source     out_valid_o / out_stall_i    status_o, achieved_baud_o,
//                                                    divisor_value_o, divisor_index_o
//  cfg       sink       cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// One item enters per cycle unless in_stall_o is high.
// Each item passes two 28-stage restoring dividers, one bit per stage.
// Reset clears all valid bits, the credit count, and loads the register defaults.
// A stalled result holds in the output register; the pipeline keeps running into a
// FifoDepth-entry queue, and the input stalls only with FifoDepth + 1 items outstanding.
module uart_baud_divisor_encoder #(
  parameter int unsigned FifoDepth = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ubde_pkg::ReqW-1:0]   requested_baud_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [ubde_pkg::ReqW-1:0]   achieved_baud_o,
  output logic [ubde_pkg::ValW-1:0]   divisor_value_o,
  output logic                        divisor_index_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [ubde_pkg::RefW-1:0]   cfg_data_i
);
  import ubde_pkg::*;

  localparam int unsigned Cap  = FifoDepth + 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 2);

  // Configuration registers.
  logic [RefW-1:0] ref_clk_q;
  logic            chip_sup_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_clk_q  <= RefClkReset;
      chip_sup_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRefClk:  ref_clk_q  <= cfg_data_i;
        CfgChipSup: chip_sup_q <= cfg_data_i[0];
        default:    ref_clk_q  <= ref_clk_q;
      endcase
    end
  end

  // Credits: items taken in and not yet transferred out.
  logic [CntW-1:0] credit_q;
  logic            in_acc, out_acc;

  assign in_stall_o = (credit_q == CntW'(Cap));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_q + CntW'(in_acc) - CntW'(out_acc);
    end
  end

  // Stage 0: status checks, base clock, and the reciprocal product for two thirds.
  logic              s0_vld_q;
  logic [ReqW-1:0]   s0_req_q;
  logic [BaseW-1:0]  s0_base_q;
  logic [ProdW-1:0]  s0_prod_q;
  status_e           s0_status_q;
  logic [BaseW-1:0]  in_base;
  status_e           in_status;

  assign in_base = ref_clk_q[RefW-1:PreShift];

  always_comb begin
    priority if (!chip_sup_q) begin
      in_status = StUnsup;
    end else if (requested_baud_i == '0) begin
      in_status = StZeroRate;
    end else begin
      in_status = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_req_q    <= requested_baud_i;
    s0_base_q   <= in_base;
    s0_prod_q   <= ProdW'({in_base, 1'b0}) * ProdW'(Recip3);
    s0_status_q <= in_status;
  end

  // Stage 1: correct the reciprocal quotient to floor(2 * base / 3).
  logic              s1_vld_q;
  side_t             s1_side_q, s1_side_d;
  logic [BaseW-1:0]  third_est;
  logic [RemW-1:0]   third_rem;

  always_comb begin
    third_est = s0_prod_q[ThirdShift +: BaseW];
    third_rem = RemW'({s0_base_q, 1'b0}) - RemW'({third_est, 1'b0}) - RemW'(third_est);
    s1_side_d.status     = s0_status_q;
    s1_side_d.req        = s0_req_q;
    s1_side_d.base       = s0_base_q;
    s1_side_d.two_thirds = (third_rem >= RemW'(DivThree)) ? third_est + 1'b1 : third_est;
    s1_side_d.ratio      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= s1_side_d;
  end

  // First divider: 16 * base / request.
  logic            d1_vld;
  logic [DivW-1:0] d1_quot;
  side_t           d1_side;

  ubde_div u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_vld_q),
    .num_i   ({s1_side_q.base, PreShift'(0)}),
    .den_i   (DivW'(s1_side_q.req)),
    .side_i  (s1_side_q),
    .valid_o (d1_vld),
    .quot_o  (d1_quot),
    .side_o  (d1_side)
  );

  // Round stage: round an odd ratio up to the next even value.
  logic            rd_vld_q;
  side_t           rd_side_q, rd_side_d;
  logic [DivW-1:0] ratio_inc;

  always_comb begin
    ratio_inc       = d1_quot + 1'b1;
    rd_side_d       = d1_side;
    rd_side_d.ratio = {ratio_inc[DivW-1:1], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_side_q <= rd_side_d;
  end

  // Second divider: 16 * base / ratio gives the achieved rate.
  logic            d2_vld;
  logic [DivW-1:0] d2_quot;
  side_t           d2_side;

  ubde_div u_div_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_vld_q),
    .num_i   ({rd_side_q.base, PreShift'(0)}),
    .den_i   (rd_side_q.ratio),
    .side_i  (rd_side_q),
    .valid_o (d2_vld),
    .quot_o  (d2_quot),
    .side_o  (d2_side)
  );

  // Final stage: pick the divisor range and pack the divisor word.
  logic             fs_vld_q;
  res_t             fs_res_q, fs_res_d;
  logic [CodeW-1:0] code;

  always_comb begin
    code              = frac_code(d2_side.ratio[PreShift-1:1]);
    fs_res_d.status   = d2_side.status;
    fs_res_d.achieved = '0;
    fs_res_d.value    = '0;
    fs_res_d.index    = 1'b0;
    priority if (d2_side.status != StOk) begin
      fs_res_d.achieved = '0;
    end else if (d2_side.req >= d2_side.base) begin
      fs_res_d.achieved = d2_side.base;
    end else if (d2_side.req >= d2_side.two_thirds) begin
      fs_res_d.achieved = d2_side.two_thirds;
      fs_res_d.value    = ValW'(1);
    end else begin
      fs_res_d.achieved = d2_quot[ReqW-1:0];
      fs_res_d.value    = {code[1:0], d2_side.ratio[PreShift +: IntW]};
      fs_res_d.index    = code[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_vld_q <= 1'b0;
    end else begin
      fs_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    fs_res_q <= fs_res_d;
  end

  // Result queue and output register.
  res_t out_res;

  ubde_out_fifo #(
    .FifoDepth (FifoDepth)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_valid_i  (fs_vld_q),
    .wr_data_i   (fs_res_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign status_o        = out_res.status;
  assign achieved_baud_o = out_res.achieved;
  assign divisor_value_o = out_res.value;
  assign divisor_index_o = out_res.index;

endmodule

// ===== hw/rtl/ubde_checker.sv =====
// Port-level checker of the baud divisor encoder, bound to the top level.
// Depends on ubde_pkg and the assertion macros in uart_baud_divisor_encoder_defines.svh.
`include "uart_baud_divisor_encoder_defines.svh"

module ubde_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [ubde_pkg::ReqW-1:0]   requested_baud_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic [ubde_pkg::ReqW-1:0]   achieved_baud_o,
  input logic [ubde_pkg::ValW-1:0]   divisor_value_o,
  input logic                        divisor_index_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o
);
  import ubde_pkg::*;

  // Items taken in whose results have not yet been transferred out.
  logic [7:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  // A stalled result stays offered and unchanged.
  `UBDE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(achieved_baud_o)
      && $stable(divisor_value_o) && $stable(divisor_index_o),
    "stalled result changed or dropped")

  // A stalled request stays offered and unchanged.
  `UBDE_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o,
    in_valid_i && $stable(requested_baud_i),
    "stalled request changed or dropped")

  // An error result carries no rate and no divisor.
  `UBDE_ASSERT_NOW(a_err_clear, out_valid_o && (status_o != StOk),
    (achieved_baud_o == '0) && (divisor_value_o == '0) && !divisor_index_o,
    "error result with nonzero fields")

  // No result is offered without an item outstanding.
  `UBDE_ASSERT_NOW(a_no_extra, out_valid_o, pending_q != '0,
    "result offered with no item outstanding")

  // The register port is always ready.
  `UBDE_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o,
    "register write not taken")

endmodule

bind uart_baud_divisor_encoder ubde_checker u_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for uart_baud_divisor_encoder: rate requests in, divisor words out.
// Depends on ubde_pkg and the block's RTL; holds its own divisor predictor and scoreboard.
module tb;
  import ubde_pkg::*;

  // Predicts each divisor word, keeps the pending ones in order and checks returned results.
  class divisor_scoreboard;
    // Fraction code for each eighth of the ratio, entry 0 in the low bits.
    localparam logic [23:0] EighthCodes =
      {3'd7, 3'd6, 3'd5, 3'd1, 3'd4, 3'd2, 3'd3, 3'd0};

    logic [RefW-1:0] ref_clk_hz;
    logic            chip_sup;
    res_t            pending_divisors[$];
    int unsigned     results_seen;
    int unsigned     mismatches;
    int unsigned     strays;

    function new();
      ref_clk_hz   = RefClkReset;
      chip_sup     = 1'b1;
      results_seen = 0;
      mismatches   = 0;
      strays       = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [RefW-1:0] data);
      if (idx == CfgRefClk) begin
        ref_clk_hz = data;
      end else begin
        chip_sup = data[0];
      end
    endfunction

    function res_t predict_divisor(logic [ReqW-1:0] req);
      logic [31:0] base;
      logic [31:0] third2;
      logic [31:0] ratio;
      logic [31:0] achieved;
      logic [31:0] whole;
      logic [2:0]  code;
      res_t        r;
      r = '0;
      if (!chip_sup) begin
        r.status = StUnsup;
      end else if (req == '0) begin
        r.status = StZeroRate;
      end else begin
        base   = {4'b0, ref_clk_hz} >> 4;
        third2 = (base * 2) / 3;
        if (req >= base) begin
          achieved = base;
          whole    = 0;
          code     = 3'd0;
        end else if (req >= third2) begin
          achieved = third2;
          whole    = 1;
          code     = 3'd0;
        end else begin
          // Round an odd 24.4 ratio up to the next even value, that is to eighths.
          ratio    = (base << 4) / req;
          ratio    = (ratio + 1) & ~32'd1;
          achieved = (base << 4) / ratio;
          whole    = ratio >> 4;
          code     = EighthCodes[ratio[3:1]*3 +: 3];
        end
        r.status   = StOk;
        r.achieved = achieved[ReqW-1:0];
        r.value    = {code[1:0], whole[IntW-1:0]};
        r.index    = code[2];
      end
      return r;
    endfunction

    function void note_request(logic [ReqW-1:0] req);
      pending_divisors.push_back(predict_divisor(req));
    endfunction

    function void check_result(logic [1:0] st, logic [ReqW-1:0] ach,
                               logic [ValW-1:0] val, logic idx);
      res_t want;
      results_seen++;
      if (pending_divisors.size() == 0) begin
        strays++;
        if (strays + mismatches <= 10)
          $display("%0t: result with nothing pending: status %0d achieved %0d value %h",
                   $realtime, st, ach, val);
        return;
      end
      want = pending_divisors.pop_front();
      if (want.status !== st || want.achieved !== ach || want.value !== val ||
          want.index !== idx) begin
        mismatches++;
        if (strays + mismatches <= 10)
          $display({"%0t: mismatch: expected status %0d achieved %0d value %h index %b,",
                    " got %0d %0d %h %b"},
                   $realtime, want.status, want.achieved, want.value, want.index,
                   st, ach, val, idx);
      end
    endfunction

    function int unsigned pending();
      return pending_divisors.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ReqW-1:0]   requested_baud_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [ReqW-1:0]   achieved_baud_o;
  logic [ValW-1:0]   divisor_value_o;
  logic              divisor_index_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = CfgRefClk;
  logic [RefW-1:0]   cfg_data_i = '0;

  divisor_scoreboard sb = new();
  bit                idling_on = 1'b1;
  int unsigned       stall_left = 0;
  int unsigned       requests_sent = 0;
  int unsigned       settings_used = 1;

  uart_baud_divisor_encoder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .requested_baud_i (requested_baud_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .achieved_baud_o  (achieved_baud_o),
    .divisor_value_o  (divisor_value_o),
    .divisor_index_o  (divisor_index_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver back-pressure in random bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (stall_left == 0 && idling_on && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 6);
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0)
      stall_left--;
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, achieved_baud_o, divisor_value_o, divisor_index_o);
  end

  // Drives one rate request and waits for its transfer.
  task automatic send_request(input logic [ReqW-1:0] req);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    requested_baud_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    requests_sent++;
  endtask

  // Lets the pipeline empty; configuration is only written while idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Writes both registers back to back with the write valid held high.
  task automatic apply_setting(input logic [RefW-1:0] ref_hz, input logic sup);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgRefClk;
    cfg_data_i  <= ref_hz;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CfgRefClk, ref_hz);
    cfg_index_i <= CfgChipSup;
    cfg_data_i  <= {{(RefW-1){1'b0}}, sup};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CfgChipSup, {{(RefW-1){1'b0}}, sup});
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Random rate, weighted toward the thresholds and toward ratios with varied eighths.
  function automatic logic [ReqW-1:0] pick_rate();
    logic [31:0] base;
    logic [31:0] third2;
    logic [31:0] r;
    int unsigned k;
    base   = {4'b0, sb.ref_clk_hz} >> 4;
    third2 = (base * 2) / 3;
    case ($urandom_range(0, 19))
      0:         r = 0;
      1, 2:      r = $urandom_range(0, 24'hFFFFFF);
      3, 4, 5:   r = base + $urandom_range(0, 4) - 2;
      6, 7, 8:   r = third2 + $urandom_range(0, 4) - 2;
      9, 10:     r = $urandom_range(1, (third2 > 1) ? third2 : 1);
      default: begin
        k = $urandom_range(1, ReqW);
        r = $urandom_range(1, (1 << k) - 1);
      end
    endcase
    // Wrapped or oversized picks saturate at the top rate.
    if (r > 32'hFFFFFF)
      r = 32'hFFFFFF;
    return r[ReqW-1:0];
  endfunction

  task automatic run_phase(input logic [RefW-1:0] ref_hz, input logic sup,
                           input int unsigned count, input bit idle);
    drain();
    apply_setting(ref_hz, sup);
    idling_on = idle;
    repeat (count) send_request(pick_rate());
  endtask

  // Stimulus: directed rates at reset defaults, then random phases over several settings.
  initial begin
    logic [ReqW-1:0] directed[$];
    directed = '{24'd0, 24'd1, 24'hFFFFFF, 24'd3000000, 24'd2999999, 24'd2000000,
                 24'd1999999, 24'd183, 24'd300, 24'd9600, 24'd115200, 24'd1200,
                 24'd19200, 24'd57600, 24'd921600, 24'd38400, 24'd230400, 24'd460800,
                 24'd1000000, 24'd75, 24'd50};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_request(directed[i]);

    run_phase(28'd48000000, 1'b1, 250, 1'b1);
    run_phase(28'hFFFFFFF, 1'b1, 250, 1'b0);
    run_phase(28'd16, 1'b1, 120, 1'b1);
    run_phase(28'd15, 1'b1, 60, 1'b1);
    run_phase(28'd0, 1'b1, 20, 1'b0);
    run_phase(RefW'($urandom_range(16, 28'hFFFFFFF)), 1'b0, 80, 1'b1);
    run_phase(RefW'($urandom_range(16, 1 << 20)), 1'b1, 250, 1'b1);
    run_phase(RefW'($urandom_range(16, 28'hFFFFFFF)), 1'b1, 270, 1'b1);
    run_phase(RefW'($urandom_range(16, 28'hFFFFFFF)), 1'b1, 270, 1'b1);
    // Last stretch runs at full rate on both sides.
    run_phase(28'd48000000, 1'b1, 250, 1'b0);

    drain();
    repeat (80) @(posedge clk_i);

    $display("Sent %0d rate requests over %0d register settings; %0d results returned.",
             requests_sent, settings_used, sb.results_seen);
    $display("Mismatches: %0d, unexpected results: %0d, still pending: %0d.",
             sb.mismatches, sb.strays, sb.pending());
    if (sb.mismatches == 0 && sb.strays == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
